### rtl/core/wfi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wfi_pkg;

    // field widths
    localparam int unsigned NUM_AXES    = 6;
    localparam int unsigned AX_W        = 3;
    localparam int unsigned COORD_W     = 32;
    localparam int unsigned DUR_W       = 22;
    localparam int unsigned PH_W        = 23;
    localparam int unsigned PERIOD_W    = 16;
    localparam int unsigned TIME_W      = 32;

    // stream payload widths
    localparam int unsigned IN_TDATA_W  = 216;
    localparam int unsigned OUT_TDATA_W = 224;

    // configuration port
    localparam int unsigned CFG_ADDR_W  = 2;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_START_X      = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_START_Y      = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_START_Z      = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_PERIOD = 2'd3;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;

    typedef logic [COORD_W-1:0] coord_t;

    // one beat into or out of the shared multiplier pipe
    typedef struct packed {
        logic            valid;
        logic [AX_W-1:0] axis;
    } mac_req_t;

endpackage

`default_nettype wire

### rtl/core/wfi_divider.sv
`timescale 1ns / 1ps
`default_nettype none

module wfi_divider #(
    parameter int unsigned QUOT_W = 16
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [wfi_pkg::DUR_W-1:0]  num,
    input  wire logic [wfi_pkg::DUR_W-1:0]  den,
    output logic                            done,
    output logic [QUOT_W-1:0]               quot
);

    localparam int unsigned CNT_W = $clog2(QUOT_W + 1);

    logic [wfi_pkg::DUR_W-1:0] rem_reg;
    logic [wfi_pkg::DUR_W-1:0] den_reg;
    logic [QUOT_W-1:0]         quot_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;

    logic [wfi_pkg::DUR_W:0]   trial;
    logic [wfi_pkg::DUR_W:0]   diff;
    logic                      ge;
    logic [wfi_pkg::DUR_W-1:0] rem_next;

    // one restoring step: shift in a zero, subtract when it fits
    always_comb begin
        trial    = {rem_reg, 1'b0};
        ge       = trial >= {1'b0, den_reg};
        diff     = trial - {1'b0, den_reg};
        rem_next = ge ? diff[wfi_pkg::DUR_W-1:0] : trial[wfi_pkg::DUR_W-1:0];
    end

    // step control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(QUOT_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num;
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[QUOT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

### rtl/core/wfi_mac.sv
`timescale 1ns / 1ps
`default_nettype none

module wfi_mac #(
    parameter int unsigned WEIGHT_W = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire wfi_pkg::mac_req_t req,
    input  wire wfi_pkg::coord_t   cur,
    input  wire wfi_pkg::coord_t   prev,
    input  wire logic [WEIGHT_W-1:0] weight,
    output wfi_pkg::mac_req_t      rsp,
    output wfi_pkg::coord_t        res
);

    localparam int unsigned DIFF_W = wfi_pkg::COORD_W + 1;
    localparam int unsigned PROD_W = DIFF_W + WEIGHT_W + 1;

    wfi_pkg::mac_req_t         req1_reg;
    wfi_pkg::mac_req_t         req2_reg;
    wfi_pkg::mac_req_t         rsp_reg;
    logic signed [DIFF_W-1:0]  diff_reg;
    wfi_pkg::coord_t           prev1_reg;
    wfi_pkg::coord_t           prev2_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    wfi_pkg::coord_t           res_reg;

    logic signed [DIFF_W-1:0]  diff_next;
    logic signed [PROD_W-1:0]  diff_ext;
    logic signed [PROD_W-1:0]  weight_ext;
    logic signed [PROD_W-1:0]  prod_next;

    always_comb begin
        diff_next  = $signed({cur[wfi_pkg::COORD_W-1], cur})
                   - $signed({prev[wfi_pkg::COORD_W-1], prev});
        diff_ext   = PROD_W'(diff_reg);
        weight_ext = PROD_W'($signed({1'b0, weight}));
        prod_next  = diff_ext * weight_ext;
    end

    // beat tracking through the three stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req1_reg <= '0;
            req2_reg <= '0;
            rsp_reg  <= '0;
        end else begin
            req1_reg <= req;
            req2_reg <= req1_reg;
            rsp_reg  <= req2_reg;
        end
    end

    // difference, product, then floor-shift and add back
    always_ff @(posedge aclk) begin
        diff_reg  <= diff_next;
        prev1_reg <= prev;
        prod_reg  <= prod_next;
        prev2_reg <= prev1_reg;
        res_reg   <= prev2_reg + prod_reg[WEIGHT_W+wfi_pkg::COORD_W-1:WEIGHT_W];
    end

    assign rsp = rsp_reg;
    assign res = res_reg;

endmodule

`default_nettype wire

### rtl/core/waypoint_frame_interpolator_top.sv
`timescale 1ns / 1ps
`default_nettype none

// A restart beat is taken in idle; a waypoint beat runs its frames in turn,
// and each frame waits while the receiver stalls the output.
// Throughput: one waypoint at a time; each frame is paced by the bit-serial
// weight divider (WEIGHT_BITS steps) and six passes through one multiplier.
// Reset: synchronous, active low; start point zero, frame period 1000,
// phase and frame clock zero, no result pending.
module waypoint_frame_interpolator_top #(
    parameter int unsigned MAX_FRAMES  = 64,
    parameter int unsigned WEIGHT_BITS = 16
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // configuration write port
    input  wire logic                               cfg_we,
    input  wire logic [wfi_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [wfi_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // waypoint stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // pos_x, pos_y, pos_z, yaw_in, pitch_in, roll_in, duration
    input  wire logic [wfi_pkg::IN_TDATA_W-1:0]     s_tdata,
    // kind
    input  wire logic                               s_tuser,
    // frame stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // out_x, out_y, out_z, out_yaw, out_pitch, out_roll, frame_time
    output logic [wfi_pkg::OUT_TDATA_W-1:0]         m_tdata,
    output logic                                    m_tlast,
    // clamped
    output logic                                    m_tuser
);

    localparam int unsigned CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int unsigned LIM_W = wfi_pkg::PH_W + 1;
    localparam int unsigned NAX   = wfi_pkg::NUM_AXES;
    localparam int unsigned CW    = wfi_pkg::COORD_W;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SETUP  = 7'b0000010,
        ST_CHECK  = 7'b0000100,
        ST_DIV    = 7'b0001000,
        ST_MUL    = 7'b0010000,
        ST_EMIT   = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    state_t state_reg;

    // configuration
    wfi_pkg::coord_t                start_x_reg;
    wfi_pkg::coord_t                start_y_reg;
    wfi_pkg::coord_t                start_z_reg;
    logic [wfi_pkg::PERIOD_W-1:0]   period_reg;

    // segment state
    wfi_pkg::coord_t                prev_reg [NAX];
    wfi_pkg::coord_t                cur_reg  [NAX];
    wfi_pkg::coord_t                res_reg  [NAX];
    logic [wfi_pkg::DUR_W-1:0]      dur_reg;
    logic [wfi_pkg::PH_W-1:0]       phase_reg;
    logic [wfi_pkg::TIME_W-1:0]     clock_reg;
    logic [CNT_W-1:0]               frame_cnt_reg;
    logic                           clamped_reg;
    logic [WEIGHT_BITS-1:0]         weight_reg;
    logic [wfi_pkg::AX_W-1:0]       issue_reg;

    // output register
    logic                           m_tvalid_reg;
    logic [wfi_pkg::OUT_TDATA_W-1:0] m_tdata_reg;
    logic                           m_tlast_reg;
    logic                           m_tuser_reg;

    logic [wfi_pkg::PERIOD_W-1:0]   eff_period;
    logic [LIM_W-1:0]               lim;
    logic                           clamp_next;
    logic [wfi_pkg::PH_W-1:0]       phase_next;
    logic                           last_next;
    logic                           in_fire;
    logic                           out_free;
    logic                           load_out;
    logic                           frame_pending;
    logic [wfi_pkg::OUT_TDATA_W-1:0] out_data_next;

    logic                           div_start;
    logic                           div_done;
    logic [WEIGHT_BITS-1:0]         div_quot;
    wfi_pkg::mac_req_t              mac_req;
    wfi_pkg::mac_req_t              mac_rsp;
    wfi_pkg::coord_t                mac_res;

    // frame arithmetic
    always_comb begin
        eff_period    = (period_reg == '0) ? wfi_pkg::PERIOD_W'(1) : period_reg;
        lim           = LIM_W'(phase_reg) + LIM_W'(eff_period) * LIM_W'(MAX_FRAMES);
        clamp_next    = lim < LIM_W'(dur_reg);
        phase_next    = phase_reg + wfi_pkg::PH_W'(eff_period);
        last_next     = (phase_next >= wfi_pkg::PH_W'(dur_reg))
                     || (frame_cnt_reg == CNT_W'(MAX_FRAMES - 1));
        frame_pending = phase_reg < wfi_pkg::PH_W'(dur_reg);
        in_fire       = s_tvalid && s_tready;
        out_free      = !m_tvalid_reg || m_tready;
        load_out      = (state_reg == ST_EMIT) && out_free;
        div_start     = (state_reg == ST_CHECK) && frame_pending;
        mac_req.valid = (state_reg == ST_MUL) && (issue_reg < wfi_pkg::AX_W'(NAX));
        mac_req.axis  = issue_reg;
        out_data_next = '0;
        for (int a = 0; a < NAX; a++) begin
            out_data_next[a*CW +: CW] = res_reg[a];
        end
        out_data_next[NAX*CW +: wfi_pkg::TIME_W] = clock_reg;
    end

    assign s_tready = (state_reg == ST_IDLE);

    // weight divider: phase * 2^WEIGHT_BITS / duration
    wfi_divider #(
        .QUOT_W (WEIGHT_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (phase_reg[wfi_pkg::DUR_W-1:0]),
        .den     (dur_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    // shared multiplier, one axis per beat
    wfi_mac #(
        .WEIGHT_W (WEIGHT_BITS)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mac_req),
        .cur     (cur_reg[issue_reg]),
        .prev    (prev_reg[issue_reg]),
        .weight  (weight_reg),
        .rsp     (mac_rsp),
        .res     (mac_res)
    );

    // sequencer and control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            start_x_reg   <= '0;
            start_y_reg   <= '0;
            start_z_reg   <= '0;
            period_reg    <= wfi_pkg::PERIOD_RESET;
            phase_reg     <= '0;
            clock_reg     <= '0;
            frame_cnt_reg <= '0;
            issue_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
            for (int a = 0; a < NAX; a++) begin
                prev_reg[a] <= '0;
            end
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    wfi_pkg::REG_START_X:      start_x_reg <= cfg_wdata;
                    wfi_pkg::REG_START_Y:      start_y_reg <= cfg_wdata;
                    wfi_pkg::REG_START_Z:      start_z_reg <= cfg_wdata;
                    wfi_pkg::REG_FRAME_PERIOD: period_reg  <= cfg_wdata[wfi_pkg::PERIOD_W-1:0];
                    default: ;
                endcase
            end

            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        if (s_tuser) begin
                            // restart from the start point
                            prev_reg[0] <= start_x_reg;
                            prev_reg[1] <= start_y_reg;
                            prev_reg[2] <= start_z_reg;
                            for (int a = 3; a < NAX; a++) begin
                                prev_reg[a] <= '0;
                            end
                            phase_reg <= '0;
                            clock_reg <= '0;
                        end else begin
                            state_reg <= ST_SETUP;
                        end
                    end
                end
                ST_SETUP: begin
                    frame_cnt_reg <= '0;
                    state_reg     <= ST_CHECK;
                end
                ST_CHECK: begin
                    state_reg <= frame_pending ? ST_DIV : ST_FINISH;
                end
                ST_DIV: begin
                    if (div_done) begin
                        issue_reg <= '0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (mac_req.valid) begin
                        issue_reg <= issue_reg + wfi_pkg::AX_W'(1);
                    end
                    if (mac_rsp.valid && mac_rsp.axis == wfi_pkg::AX_W'(NAX - 1)) begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        phase_reg     <= phase_next;
                        clock_reg     <= clock_reg + wfi_pkg::TIME_W'(eff_period);
                        frame_cnt_reg <= frame_cnt_reg + CNT_W'(1);
                        state_reg     <= last_next ? ST_FINISH : ST_CHECK;
                    end
                end
                ST_FINISH: begin
                    // carry the leftover phase; a clamped segment drops it
                    phase_reg <= frame_pending ? '0 : phase_reg - wfi_pkg::PH_W'(dur_reg);
                    for (int a = 0; a < NAX; a++) begin
                        prev_reg[a] <= cur_reg[a];
                    end
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_fire && !s_tuser) begin
            for (int a = 0; a < NAX; a++) begin
                cur_reg[a] <= s_tdata[a*CW +: CW];
            end
            dur_reg <= s_tdata[NAX*CW +: wfi_pkg::DUR_W];
        end
        if (state_reg == ST_SETUP) begin
            clamped_reg <= clamp_next;
        end
        if (div_done) begin
            weight_reg <= div_quot;
        end
        if (mac_rsp.valid) begin
            res_reg[mac_rsp.axis] <= mac_res;
        end
        if (load_out) begin
            m_tdata_reg <= out_data_next;
            m_tlast_reg <= last_next;
            m_tuser_reg <= clamped_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    // the divider only finishes while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider result outside the weight step");

    // multiplier results only arrive during the axis pass
    assert property (@(posedge aclk) disable iff (!aresetn)
        mac_rsp.valid |-> (state_reg == ST_MUL))
        else $error("multiplier result outside the axis pass");

    // a new frame never starts past the frame limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK) |-> (frame_cnt_reg < CNT_W'(MAX_FRAMES)))
        else $error("frame count past the limit");

endmodule

`default_nettype wire
